// ===== rtl/core/fwf_pkg.sv =====
package fwf_pkg;

    localparam int unsigned HIST_DEPTH_DEFAULT = 25;

    localparam int unsigned DIST_W     = 10;
    localparam int unsigned DUTY_W     = 7;
    localparam int unsigned REJ_W      = 3;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    // drive modes
    localparam logic [MODE_W-1:0] MODE_LEFT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT    = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPIKE_MARGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REJECTS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DUTY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_DUTY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DUTY    = 3'd4;

    // configuration reset values
    localparam logic [DIST_W-1:0] SPIKE_MARGIN_RST = 10'd20;
    localparam logic [REJ_W-1:0]  MAX_REJECTS_RST  = 3'd4;
    localparam logic [DUTY_W-1:0] CRUISE_DUTY_RST  = 7'd70;
    localparam logic [DUTY_W-1:0] SLOW_DUTY_RST    = 7'd50;
    localparam logic [DUTY_W-1:0] TURN_DUTY_RST    = 7'd50;

    // wall follower thresholds, inches
    localparam logic [DIST_W-1:0] WALL_NEAR_TH   = 10'd20;
    localparam logic [DIST_W-1:0] CENTER_OPEN_TH = 10'd11;
    localparam logic [DIST_W-1:0] CORNER_TH      = 10'd12;
    localparam logic [DIST_W-1:0] WALL_LOST_TH   = 10'd15;
    localparam logic [DIST_W-1:0] TREND_BAND     = 10'd3;

    typedef struct packed {
        logic [MODE_W-1:0] drive_mode;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic [MODE_W-1:0] next_mode;
        logic [DIST_W-1:0] filtered_left;
        logic [DIST_W-1:0] filtered_center;
    } result_t;

endpackage

// ===== rtl/core/fwf_channel.sv =====
module fwf_channel
    import fwf_pkg::*;
#(
    parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              advance,
    input  logic              limit_en,
    input  logic [DIST_W-1:0] reading,
    input  logic [DIST_W-1:0] margin,
    input  logic [REJ_W-1:0]  max_rejects,
    output logic [DIST_W-1:0] avg,
    output logic [DIST_W-1:0] written
);

    localparam int unsigned DepthLog   = $clog2(HIST_DEPTH);
    localparam int unsigned SumW       = DIST_W + DepthLog;
    localparam int unsigned MulW       = SumW + 1;
    localparam int unsigned ProdW      = SumW + MulW;
    localparam int unsigned RecipShift = SumW + DepthLog;
    localparam logic [MulW-1:0] RecipMul =
        MulW'(((64'd1 << RecipShift) + HIST_DEPTH - 1) / HIST_DEPTH);

    // entry 0 is the current slot, the last entry is the previous slot
    logic [DIST_W-1:0] hist_reg  [HIST_DEPTH];
    logic [DIST_W-1:0] hist_next [HIST_DEPTH];
    logic [SumW-1:0]   sum_reg, sum_next;
    logic [REJ_W-1:0]  run_reg, run_next;
    logic [ProdW-1:0]  prod;
    logic              spike;
    logic              take_prev;

    // sum / depth through reciprocal multiply, exact over the sum's range
    assign prod = ProdW'(sum_reg) * ProdW'(RecipMul);
    assign avg  = prod[RecipShift +: DIST_W];

    assign spike = {1'b0, reading} > ({1'b0, avg} + {1'b0, margin});

    always_comb begin
        take_prev = spike;
        run_next  = '0;
        if (limit_en) begin
            take_prev = spike && (run_reg < max_rejects);
            if (take_prev) begin
                run_next = run_reg + 1'b1;
            end
        end
    end

    assign written  = take_prev ? hist_reg[HIST_DEPTH-1] : reading;
    assign sum_next = sum_reg - SumW'(hist_reg[0]) + SumW'(written);

    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_next[k] = hist_reg[k];
        end
        if (advance) begin
            // rotate: the written slot becomes the previous slot
            for (int k = 0; k < HIST_DEPTH - 1; k++) begin
                hist_next[k] = hist_reg[k+1];
            end
            hist_next[HIST_DEPTH-1] = written;
        end else begin
            hist_next[0] = written;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= '0;
            end
            sum_reg <= '0;
            run_reg <= '0;
        end else if (accept) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= hist_next[k];
            end
            sum_reg <= sum_next;
            run_reg <= run_next;
        end
    end

endmodule

// ===== rtl/core/fwf_decide.sv =====
module fwf_decide
    import fwf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              decide,
    input  logic [DIST_W-1:0] filt_left,
    input  logic [DIST_W-1:0] filt_center,
    input  logic [DIST_W-1:0] left_avg,
    input  logic [DUTY_W-1:0] cruise_duty,
    input  logic [DUTY_W-1:0] slow_duty,
    input  logic [DUTY_W-1:0] turn_duty,
    output result_t           result
);

    logic [MODE_W-1:0] state_reg, state_next;
    logic [MODE_W-1:0] mode;
    logic [DUTY_W-1:0] lduty, rduty;
    logic              in_band;
    logic              drifting_in;

    assign in_band = (({1'b0, filt_left} + {1'b0, TREND_BAND}) > {1'b0, left_avg})
                  && ({1'b0, filt_left} < ({1'b0, left_avg} + {1'b0, TREND_BAND}));
    assign drifting_in = filt_left < left_avg;

    always_comb begin
        mode       = state_reg;
        state_next = state_reg;
        lduty      = turn_duty;
        rduty      = turn_duty;
        case (state_reg)
            MODE_LEFT: begin
                if (filt_left < WALL_NEAR_TH && filt_center > CENTER_OPEN_TH) begin
                    state_next = MODE_STRAIGHT;
                end else if (filt_left < CORNER_TH && filt_center < CORNER_TH) begin
                    state_next = MODE_RIGHT;
                end
            end
            MODE_RIGHT: begin
                if (filt_left > WALL_NEAR_TH) begin
                    state_next = MODE_LEFT;
                end else if (filt_center > WALL_LOST_TH) begin
                    state_next = MODE_STRAIGHT;
                end
            end
            default: begin
                mode       = MODE_STRAIGHT;
                state_next = MODE_STRAIGHT;
                if (in_band) begin
                    lduty = cruise_duty;
                    rduty = cruise_duty;
                end else if (drifting_in) begin
                    lduty = cruise_duty;
                    rduty = slow_duty;
                end else begin
                    lduty = slow_duty;
                    rduty = cruise_duty;
                end
                if (filt_left >= WALL_LOST_TH) begin
                    state_next = MODE_LEFT;
                end else if (filt_left < WALL_NEAR_TH && filt_center < WALL_LOST_TH) begin
                    state_next = MODE_RIGHT;
                end
            end
        endcase
    end

    assign result.drive_mode      = mode;
    assign result.left_duty       = lduty;
    assign result.right_duty      = rduty;
    assign result.next_mode       = state_next;
    assign result.filtered_left   = filt_left;
    assign result.filtered_center = filt_center;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MODE_STRAIGHT;
        end else if (accept && decide) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/fwf_out_buf.sv =====
module fwf_out_buf
    import fwf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    result_t head_reg, head_next;
    result_t skid_reg, skid_next;
    logic    head_valid_reg, head_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    pop;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_reg;
    assign pop        = head_valid_reg && pop_ready;

    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg) begin
            // drain the skid entry into the head
            if (pop) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push_valid) begin
            if (!head_valid_reg || pop) begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end else begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== rtl/core/filtered_wall_follower.sv =====
// Spike-filtered three-sensor wall follower. Each accepted transaction carries left, center
// and right distances and a decide flag; every transaction updates the three HIST_DEPTH-entry
// histories, and a decide transaction also runs the turn-left / straight / turn-right state
// machine and produces one result into the output buffer. A transaction is taken every clock
// cycle while s_ready is high: the channel averages come from running sums scaled by a fixed
// reciprocal multiply, so the critical path is that multiply, a compare and the state
// machine. Results sit in an output register backed by one skid entry; s_ready drops only
// while both hold an untaken result. Configuration writes are registered and must be issued
// while no transaction is in flight.
module filtered_wall_follower
    import fwf_pkg::*;
#(
    parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DIST_W-1:0]     s_left_distance,
    input  logic [DIST_W-1:0]     s_center_distance,
    input  logic [DIST_W-1:0]     s_right_distance,
    input  logic                  s_decide_tick,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MODE_W-1:0]     m_drive_mode,
    output logic [DUTY_W-1:0]     m_left_duty,
    output logic [DUTY_W-1:0]     m_right_duty,
    output logic [MODE_W-1:0]     m_next_mode,
    output logic [DIST_W-1:0]     m_filtered_left,
    output logic [DIST_W-1:0]     m_filtered_center
);

    logic [DIST_W-1:0] margin_reg;
    logic [REJ_W-1:0]  max_rej_reg;
    logic [DUTY_W-1:0] cruise_reg;
    logic [DUTY_W-1:0] slow_reg;
    logic [DUTY_W-1:0] turn_reg;

    logic              accept;
    logic              push_valid;
    logic [DIST_W-1:0] left_avg, center_avg, right_avg;
    logic [DIST_W-1:0] left_wr, center_wr, right_wr;
    result_t           decide_result;
    result_t           out_data;

    assign cfg_ready  = 1'b1;
    assign accept     = s_valid && s_ready;
    assign push_valid = accept && s_decide_tick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg  <= SPIKE_MARGIN_RST;
            max_rej_reg <= MAX_REJECTS_RST;
            cruise_reg  <= CRUISE_DUTY_RST;
            slow_reg    <= SLOW_DUTY_RST;
            turn_reg    <= TURN_DUTY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SPIKE_MARGIN: margin_reg  <= cfg_data[DIST_W-1:0];
                REG_MAX_REJECTS:  max_rej_reg <= cfg_data[REJ_W-1:0];
                REG_CRUISE_DUTY:  cruise_reg  <= cfg_data[DUTY_W-1:0];
                REG_SLOW_DUTY:    slow_reg    <= cfg_data[DUTY_W-1:0];
                REG_TURN_DUTY:    turn_reg    <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    fwf_channel #(.HIST_DEPTH(HIST_DEPTH)) u_left (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .advance     (s_decide_tick),
        .limit_en    (1'b1),
        .reading     (s_left_distance),
        .margin      (margin_reg),
        .max_rejects (max_rej_reg),
        .avg         (left_avg),
        .written     (left_wr)
    );

    fwf_channel #(.HIST_DEPTH(HIST_DEPTH)) u_center (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .advance     (s_decide_tick),
        .limit_en    (1'b1),
        .reading     (s_center_distance),
        .margin      (margin_reg),
        .max_rejects (max_rej_reg),
        .avg         (center_avg),
        .written     (center_wr)
    );

    // right channel rejects every spike, no run limit
    fwf_channel #(.HIST_DEPTH(HIST_DEPTH)) u_right (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .advance     (s_decide_tick),
        .limit_en    (1'b0),
        .reading     (s_right_distance),
        .margin      (margin_reg),
        .max_rejects (max_rej_reg),
        .avg         (right_avg),
        .written     (right_wr)
    );

    fwf_decide u_decide (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .decide      (s_decide_tick),
        .filt_left   (left_wr),
        .filt_center (center_wr),
        .left_avg    (left_avg),
        .cruise_duty (cruise_reg),
        .slow_duty   (slow_reg),
        .turn_duty   (turn_reg),
        .result      (decide_result)
    );

    fwf_out_buf u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (s_ready),
        .push_data  (decide_result),
        .pop_valid  (m_valid),
        .pop_ready  (m_ready),
        .pop_data   (out_data)
    );

    assign m_drive_mode      = out_data.drive_mode;
    assign m_left_duty       = out_data.left_duty;
    assign m_right_duty      = out_data.right_duty;
    assign m_next_mode       = out_data.next_mode;
    assign m_filtered_left   = out_data.filtered_left;
    assign m_filtered_center = out_data.filtered_center;

endmodule

// ===== rtl/core/fwf_checker.sv =====
module fwf_port_checker
    import fwf_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [MODE_W-1:0]     m_drive_mode,
    input logic [DUTY_W-1:0]     m_left_duty,
    input logic [DUTY_W-1:0]     m_right_duty,
    input logic [MODE_W-1:0]     m_next_mode,
    input logic [DIST_W-1:0]     m_filtered_left,
    input logic [DIST_W-1:0]     m_filtered_center
);

    // no result may survive a reset
    a_idle_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // input back-pressure only when a result is already waiting
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

    a_mode_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_mode <= MODE_RIGHT && m_next_mode <= MODE_RIGHT))
        else $error("unused mode code on result");

    // in-place turns drive both wheels at the same duty
    a_turn_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_mode == MODE_LEFT || m_drive_mode == MODE_RIGHT))
            |-> m_left_duty == m_right_duty)
        else $error("turn result with unequal duties");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drive_mode)
            && $stable(m_left_duty) && $stable(m_right_duty) && $stable(m_next_mode)
            && $stable(m_filtered_left) && $stable(m_filtered_center)))
        else $error("stalled result dropped or changed");

endmodule

bind filtered_wall_follower fwf_port_checker u_fwf_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_drive_mode      (m_drive_mode),
    .m_left_duty       (m_left_duty),
    .m_right_duty      (m_right_duty),
    .m_next_mode       (m_next_mode),
    .m_filtered_left   (m_filtered_left),
    .m_filtered_center (m_filtered_center)
);
